### rtl/core/mhpq_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
// Holds the store geometry, action and status codes and the control structs.
// No dependencies.
package mhpq_pkg;

    // Store geometry.
    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = ADDR_W + 2;

    // Widths of the item fields.
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUILD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNORDERED = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                accept;
        logic [STATUS_W-1:0] status_code;
        logic                load_write;
        logic                pop_begin;
        logic                node_zero;
        logic                latch_cur;
        logic                build_begin;
        logic                build_next;
        logic                rd_left;
        logic                rd_right;
        logic                latch_left;
        logic                step;
        logic                place;
        logic                set_ordered;
    } mhpq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic ordered;
        logic leaf;
        logic child_greater;
        logic bidx_zero;
    } mhpq_sts_t;

endpackage

### rtl/core/mhpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/mhpq_dp.sv
// Datapath of the heap: store, count, order mark, sift registers and result values.
// Depends on mhpq_pkg and mhpq_ram.
module mhpq_dp
    import mhpq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  mhpq_cmd_t                 cmd,
    output mhpq_sts_t                 sts,
    output logic signed [VALUE_W-1:0] top_value,
    output logic signed [VALUE_W-1:0] removed_value,
    output logic [COUNT_W-1:0]        entry_count,
    output logic [STATUS_W-1:0]       status
);

    logic [CNT_W-1:0]    count_reg;
    logic                ordered_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   node_reg;
    logic [ADDR_W-1:0]   bidx_reg;
    data_t               cur_reg;
    data_t               left_reg;
    data_t               root_reg;
    data_t               removed_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    data_t             wdata;
    logic [ADDR_W-1:0] raddr;
    logic [DATA_WIDTH-1:0] rdata_raw;
    data_t             rdata;

    logic [IDX_W-1:0]  lc_idx;
    logic [IDX_W-1:0]  rc_idx;
    logic              has_right;
    logic              right_wins;
    data_t             best_val;
    logic [ADDR_W-1:0] best_idx;

    mhpq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = data_t'(rdata_raw);

    // Child indices of the current node and the larger child.
    always_comb
    begin
        lc_idx     = IDX_W'({node_reg, 1'b1});
        rc_idx     = lc_idx + IDX_W'(1);
        has_right  = rc_idx < IDX_W'(count_reg);
        right_wins = has_right && (rdata > left_reg);
        best_val   = right_wins ? rdata : left_reg;
        best_idx   = right_wins ? ADDR_W'(rc_idx) : ADDR_W'(lc_idx);
    end

    // Store write port: append on load, move a child up, or place the sifted item.
    always_comb
    begin
        we    = 1'b0;
        waddr = node_reg;
        wdata = cur_reg;
        if (cmd.load_write)
        begin
            we    = 1'b1;
            waddr = ADDR_W'(count_reg);
            wdata = DATA_WIDTH'(value);
        end
        else if (cmd.step)
        begin
            we    = 1'b1;
            wdata = best_val;
        end
        else if (cmd.place)
        begin
            we = 1'b1;
        end
    end

    // Store read port.
    always_comb
    begin
        raddr = ADDR_W'(rc_idx);
        if (cmd.pop_begin)
        begin
            raddr = ADDR_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.build_next)
        begin
            raddr = bidx_reg - ADDR_W'(1);
        end
        else if (cmd.rd_left)
        begin
            raddr = ADDR_W'(lc_idx);
        end
        else if (cmd.rd_right)
        begin
            raddr = ADDR_W'(rc_idx);
        end
    end

    // Control state of the store: count and order mark.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ordered_reg <= 1'b1;
        end
        else
        begin
            if (cmd.load_write)
            begin
                count_reg   <= count_reg + CNT_W'(1);
                ordered_reg <= 1'b0;
            end
            else if (cmd.pop_begin)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.set_ordered)
            begin
                ordered_reg <= 1'b1;
            end
        end
    end

    // Sift registers, root copy and result values.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg  <= cmd.status_code;
            removed_reg <= '0;
        end
        if (cmd.pop_begin)
        begin
            removed_reg <= root_reg;
        end
        if (cmd.build_begin)
        begin
            bidx_reg <= ADDR_W'(count_reg >> 1);
        end
        if (cmd.build_next)
        begin
            bidx_reg <= bidx_reg - ADDR_W'(1);
            node_reg <= bidx_reg - ADDR_W'(1);
        end
        if (cmd.node_zero)
        begin
            node_reg <= '0;
        end
        if (cmd.latch_cur)
        begin
            cur_reg <= rdata;
        end
        if (cmd.latch_left)
        begin
            left_reg <= rdata;
        end
        if (cmd.step)
        begin
            node_reg <= best_idx;
        end
        if (we && (waddr == '0))
        begin
            root_reg <= wdata;
        end
    end

    // Status towards the controller.
    always_comb
    begin
        sts.full          = count_reg == CNT_W'(CAPACITY);
        sts.empty         = count_reg == '0;
        sts.ordered       = ordered_reg;
        sts.leaf          = lc_idx >= IDX_W'(count_reg);
        sts.child_greater = best_val > cur_reg;
        sts.bidx_zero     = bidx_reg == '0;
    end

    // Result fields.
    assign top_value     = (ordered_reg && (count_reg != '0)) ? VALUE_W'(root_reg) : '0;
    assign removed_value = VALUE_W'(removed_reg);
    assign entry_count   = COUNT_W'(count_reg);
    assign status        = status_reg;

endmodule

### rtl/core/mhpq_ctrl.sv
// Controller state machine of the heap: decodes actions and sequences sift-down.
// Depends on mhpq_pkg.
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACTION_W-1:0] action,
    input  mhpq_sts_t           sts,
    output mhpq_cmd_t           cmd,
    output logic                busy,
    output logic                done
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_POP_LD   = 4'd1;
    localparam logic [3:0] S_BLD_NEXT = 4'd2;
    localparam logic [3:0] S_BLD_LD   = 4'd3;
    localparam logic [3:0] S_SIFT_L   = 4'd4;
    localparam logic [3:0] S_SIFT_R   = 4'd5;
    localparam logic [3:0] S_SIFT_CMP = 4'd6;
    localparam logic [3:0] S_DONE     = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       build_reg;
    logic       build_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept      = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_DONE;
                    unique case (action)
                        ACT_LOAD:
                        begin
                            if (sts.full)
                            begin
                                cmd.status_code = ST_FULL;
                            end
                            else
                            begin
                                cmd.load_write = 1'b1;
                            end
                        end
                        ACT_BUILD:
                        begin
                            cmd.build_begin = 1'b1;
                            build_next      = 1'b1;
                            state_next      = S_BLD_NEXT;
                        end
                        ACT_POP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.status_code = ST_EMPTY;
                            end
                            else if (!sts.ordered)
                            begin
                                cmd.status_code = ST_UNORDERED;
                            end
                            else
                            begin
                                cmd.pop_begin = 1'b1;
                                build_next    = 1'b0;
                                state_next    = S_POP_LD;
                            end
                        end
                        ACT_NOP:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_POP_LD:
            begin
                cmd.latch_cur = 1'b1;
                cmd.node_zero = 1'b1;
                state_next    = S_SIFT_L;
            end
            S_BLD_NEXT:
            begin
                if (sts.bidx_zero)
                begin
                    cmd.set_ordered = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.build_next = 1'b1;
                    state_next     = S_BLD_LD;
                end
            end
            S_BLD_LD:
            begin
                cmd.latch_cur = 1'b1;
                state_next    = S_SIFT_L;
            end
            S_SIFT_L:
            begin
                if (sts.leaf)
                begin
                    cmd.place  = 1'b1;
                    state_next = build_reg ? S_BLD_NEXT : S_DONE;
                end
                else
                begin
                    cmd.rd_left = 1'b1;
                    state_next  = S_SIFT_R;
                end
            end
            S_SIFT_R:
            begin
                cmd.latch_left = 1'b1;
                cmd.rd_right   = 1'b1;
                state_next     = S_SIFT_CMP;
            end
            S_SIFT_CMP:
            begin
                if (sts.child_greater)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SIFT_L;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = build_reg ? S_BLD_NEXT : S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

endmodule

### rtl/core/max_heap_priority_queue_unit.sv
// Binary max-heap priority queue: load, build and pop on a store of signed words.
// Load, no-op and refused actions go straight to the result; a pop and a build sift down level
// by level, a build once per parent from the last parent to the root. One store read port
// means the two children of a level are read one after the other. The next item is taken
// the cycle after each result and the receiver cannot stall. Reset clears the count,
// sets the store ordered and leaves the store contents undefined (no clearing pass).
module max_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      busy,
    output logic                      done,
    output logic signed [VALUE_W-1:0] top_value,
    output logic signed [VALUE_W-1:0] removed_value,
    output logic [COUNT_W-1:0]        entry_count,
    output logic [STATUS_W-1:0]       status
);

    mhpq_cmd_t cmd;
    mhpq_sts_t sts;

    // Controller.
    mhpq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath.
    mhpq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .cmd           (cmd),
        .sts           (sts),
        .top_value     (top_value),
        .removed_value (removed_value),
        .entry_count   (entry_count),
        .status        (status)
    );

    // A result is shown for one cycle only.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    // An accepted item keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("Accepted item did not make the block busy.");

    // A refused load is reported only when the store is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (entry_count == COUNT_W'(CAPACITY)))
        else $error("Full status reported with spare room in the store.");

    // A refused action never reports a removed item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (removed_value == '0))
        else $error("Refused action reported a removed item.");

endmodule

### test/max_heap_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the max-heap priority queue: load, build and pop items.
// A scoreboard class keeps its own heap and predicts every result; depends on mhpq_pkg
// and max_heap_priority_queue_unit.
module max_heap_priority_queue_unit_tb;
    import mhpq_pkg::*;

    localparam int ITEM_TARGET  = 850;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 64;

    // One predicted result of the block.
    typedef struct packed {
        data_t               top;
        data_t               removed;
        logic [COUNT_W-1:0]  entries;
        logic [STATUS_W-1:0] status;
    } heap_report_t;

    // Scoreboard: a heap of its own, and the results still to arrive, oldest first.
    class heap_scoreboard;
        data_t        heap_mem [CAPACITY];
        int unsigned  held;
        bit           in_order;
        heap_report_t expected_reports [$];
        int unsigned  fail_count;

        function new();
            held       = 0;
            in_order   = 1'b1;
            fail_count = 0;
        endfunction

        // Move a node down until neither child is strictly greater; left wins ties.
        function void sift_down(int unsigned node, int unsigned cnt);
            int unsigned left_idx;
            int unsigned right_idx;
            int unsigned best;
            data_t       swap_word;
            bit          settled;
            settled = 1'b0;
            while (!settled) begin
                left_idx  = 2 * node + 1;
                right_idx = left_idx + 1;
                best      = node;
                if (left_idx < cnt && heap_mem[left_idx] > heap_mem[best])
                    best = left_idx;
                if (right_idx < cnt && heap_mem[right_idx] > heap_mem[best])
                    best = right_idx;
                if (best == node) begin
                    settled = 1'b1;
                end
                else begin
                    swap_word      = heap_mem[node];
                    heap_mem[node] = heap_mem[best];
                    heap_mem[best] = swap_word;
                    node           = best;
                end
            end
        endfunction

        // Apply an accepted item to the heap and queue the result it must give.
        function void note_item(logic [ACTION_W-1:0] act, data_t val);
            heap_report_t rep;
            rep.top     = '0;
            rep.removed = '0;
            rep.status  = ST_OK;
            case (act)
                ACT_LOAD:
                begin
                    if (held >= CAPACITY) begin
                        rep.status = ST_FULL;
                    end
                    else begin
                        heap_mem[held] = val;
                        held++;
                        in_order = 1'b0;
                    end
                end
                ACT_BUILD:
                begin
                    for (int unsigned i = held / 2; i > 0; i--)
                        sift_down(i - 1, held);
                    in_order = 1'b1;
                end
                ACT_POP:
                begin
                    if (held == 0) begin
                        rep.status = ST_EMPTY;
                    end
                    else if (!in_order) begin
                        rep.status = ST_UNORDERED;
                    end
                    else begin
                        rep.removed = heap_mem[0];
                        held--;
                        heap_mem[0] = heap_mem[held];
                        sift_down(0, held);
                    end
                end
                default:
                begin
                end
            endcase
            if (in_order && held > 0)
                rep.top = heap_mem[0];
            rep.entries = COUNT_W'(held);
            expected_reports.push_back(rep);
        endfunction

        // Compare one result with the oldest prediction, field by field.
        function void check_result(data_t top, data_t removed, logic [COUNT_W-1:0] entries,
                                   logic [STATUS_W-1:0] st);
            heap_report_t want;
            if (expected_reports.size() == 0) begin
                $error("result strobe with no item outstanding");
                fail_count++;
                return;
            end
            want = expected_reports.pop_front();
            if (want.top !== top) begin
                $error("top_value: expected %0d, got %0d", want.top, top);
                fail_count++;
            end
            if (want.removed !== removed) begin
                $error("removed_value: expected %0d, got %0d", want.removed, removed);
                fail_count++;
            end
            if (want.entries !== entries) begin
                $error("entry_count: expected %0d, got %0d", want.entries, entries);
                fail_count++;
            end
            if (want.status !== st) begin
                $error("status: expected %0d, got %0d", want.status, st);
                fail_count++;
            end
        endfunction
    endclass

    logic                      clk    = 1'b0;
    logic                      rst_n  = 1'b0;
    logic                      start  = 1'b0;
    logic [ACTION_W-1:0]       action = ACT_NOP;
    logic signed [VALUE_W-1:0] value  = '0;
    logic                      busy;
    logic                      done;
    logic signed [VALUE_W-1:0] top_value;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;
    logic [STATUS_W-1:0]       status;

    heap_scoreboard sb;
    int unsigned    issued      = 0;
    int unsigned    cycle_count = 0;
    int             idle_plan [4] = '{0, 46, 0, 26};

    max_heap_priority_queue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .value         (value),
        .busy          (busy),
        .done          (done),
        .top_value     (top_value),
        .removed_value (removed_value),
        .entry_count   (entry_count),
        .status        (status)
    );

    // Clock with an 8 ns period.
    always #4 clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Every result strobe is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(top_value, removed_value, entry_count, status);
    end

    // Random value: either the whole range or a narrow band that gives equal keys.
    function automatic data_t pick_value(bit narrow);
        if (narrow)
            return $signed($urandom_range(0, 6)) - 32'sd3;
        return $signed($urandom());
    endfunction

    // Offer one item, idling first at the rate of the current phase, and wait for acceptance.
    task automatic send_item(input logic [ACTION_W-1:0] act, input data_t val);
        int idle_pct;
        idle_pct = idle_plan[(issued / 100) % 4];
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_item(act, val);
        issued++;
    endtask

    initial
    begin
        int unsigned n_loads;
        int unsigned n_pops;
        bit          narrow;
        bit          filled;
        sb     = new();
        filled = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, single entry, a root with only a left child, extremes, ties.
        send_item(ACT_POP, 32'sd0);
        send_item(ACT_BUILD, 32'sd0);
        send_item(ACT_NOP, 32'sd0);
        send_item(ACT_LOAD, 32'sh7FFF_FFFF);
        send_item(ACT_BUILD, 32'sd0);
        send_item(ACT_POP, 32'sd0);
        send_item(ACT_LOAD, $signed(32'h8000_0000));
        send_item(ACT_LOAD, 32'sh7FFF_FFFF);
        send_item(ACT_POP, 32'sd0);
        send_item(ACT_BUILD, 32'sd0);
        send_item(ACT_POP, 32'sd0);
        send_item(ACT_POP, 32'sd0);
        send_item(ACT_POP, 32'sd0);
        send_item(ACT_LOAD, 32'sd0);
        send_item(ACT_LOAD, -32'sd1);
        send_item(ACT_LOAD, 32'sd5);
        send_item(ACT_LOAD, 32'sd5);
        send_item(ACT_LOAD, 32'sd7);
        send_item(ACT_LOAD, 32'sd7);
        send_item(ACT_NOP, 32'sd0);
        send_item(ACT_BUILD, 32'sd0);
        send_item(ACT_POP, 32'sd0);
        send_item(ACT_POP, 32'sd0);

        // Random: mostly load-build-pop runs, one fill past capacity, the rest single items.
        while (issued < ITEM_TARGET) begin
            if (!filled && issued > 350) begin
                while (sb.held < CAPACITY)
                    send_item(ACT_LOAD, pick_value(1'b0));
                repeat (3) send_item(ACT_LOAD, pick_value(1'b0));
                send_item(ACT_POP, pick_value(1'b0));
                send_item(ACT_BUILD, pick_value(1'b0));
                filled = 1'b1;
            end
            else if ($urandom_range(0, 99) < 70) begin
                narrow  = ($urandom_range(0, 99) < 30);
                n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
                repeat (n_loads) send_item(ACT_LOAD, pick_value(narrow));
                if ($urandom_range(0, 99) < 15)
                    send_item(ACT_POP, pick_value(1'b0));
                send_item(ACT_BUILD, pick_value(1'b0));
                n_pops = ($urandom_range(0, 99) < 40) ? $urandom_range(1, sb.held + 1)
                                                      : $urandom_range(1, 4);
                repeat (n_pops) send_item(ACT_POP, pick_value(1'b0));
            end
            else begin
                send_item(ACTION_W'($urandom_range(0, 3)), pick_value(1'($urandom_range(0, 1))));
            end
        end
        start <= 1'b0;

        // Wait for every outstanding result, then a little longer for stray strobes.
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
